// File: hdl/tlrm_pkg.sv
`default_nettype none

// Widths of the external fields, fixed by the interface of the block.
package tlrm_pkg;

    // Radii and thickness arrive as signed Q16.16 words.
    localparam int IN_BITS  = 32;

    // The refractive index arrives as an unsigned Q5.16 value.
    localparam int IDX_BITS = 21;

    // The matrix elements leave as signed Q16.16 words.
    localparam int OUT_BITS = 32;

endpackage

`default_nettype wire

// File: hdl/tlrm_recip.sv
`default_nettype none

// Pipelined reciprocal 2^(2F)/x of a signed word, truncated toward zero and saturated.
// One restoring-division step per stage gives one quotient bit per stage.
// A new operand may enter in every cycle.
module tlrm_recip #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                i_clk,
    input  wire logic signed [W-1:0] i_den,
    output logic signed [W-1:0]      o_quo,
    output logic                     o_ovf
);

    localparam int QW = 2 * F + 1;
    localparam int CW = (QW > W ? QW : W) + 1;
    localparam logic [CW-1:0] LIM  = {{(CW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [CW-1:0] LIMN = LIM + CW'(1);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};

    logic [W-1:0]  r_dm   [QW+1];
    logic [W-1:0]  r_rem  [QW+1];
    logic [QW-1:0] r_q    [QW+1];
    logic          r_neg  [QW+1];
    logic          r_zero [QW+1];

    logic [W:0]          trial [QW];
    logic                ge    [QW];
    logic [CW-1:0]       mag;
    logic signed [W-1:0] n_quo;
    logic                n_ovf;
    logic signed [W-1:0] r_quo;
    logic                r_ovf;

    // Each stage shifts one dividend bit into the remainder and tries a subtraction.
    // The dividend is a single one at bit 2F, so only the first stage brings in a one.
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial[k] = {r_rem[k], (k == 0) ? 1'b1 : 1'b0};
            ge[k]    = (trial[k] >= {1'b0, r_dm[k]});
        end
    end

    // The magnitude of the divisor is taken on entry, then the division stages follow.
    always_ff @(posedge i_clk) begin
        r_dm[0]   <= i_den[W-1] ? W'(-i_den) : W'(i_den);
        r_rem[0]  <= '0;
        r_q[0]    <= '0;
        r_neg[0]  <= i_den[W-1];
        r_zero[0] <= (i_den == '0);
        for (int k = 0; k < QW; k++) begin
            r_dm[k+1]   <= r_dm[k];
            r_rem[k+1]  <= ge[k] ? W'(trial[k] - {1'b0, r_dm[k]}) : W'(trial[k]);
            r_q[k+1]    <= {r_q[k][QW-2:0], ge[k]};
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    // The quotient gets its sign and is saturated to the word range.
    // A zero divisor gives the largest positive word.
    always_comb begin
        mag   = CW'(r_q[QW]);
        n_quo = W'(mag);
        n_ovf = 1'b0;
        if (r_zero[QW]) begin
            n_quo = WMAX;
            n_ovf = 1'b1;
        end else if (r_neg[QW]) begin
            if (mag > LIMN) begin
                n_quo = WMIN;
                n_ovf = 1'b1;
            end else begin
                n_quo = W'(-mag);
            end
        end else if (mag > LIM) begin
            n_quo = WMAX;
            n_ovf = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_ovf <= n_ovf;
    end

    assign o_quo = r_quo;
    assign o_ovf = r_ovf;

endmodule

`default_nettype wire

// File: hdl/tlrm_mul.sv
`default_nettype none

// Pipelined fixed-point multiply: the exact product is shifted right by F, truncating
// toward zero, and saturated to the word range. The magnitudes are split into halves
// so that no single multiplier is wider than half a word.
module tlrm_mul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                i_clk,
    input  wire logic signed [W-1:0] i_a,
    input  wire logic signed [W-1:0] i_b,
    output logic signed [W-1:0]      o_prod,
    output logic                     o_ovf
);

    localparam int HB = (W + 1) / 2;
    localparam int DB = 2 * HB;
    localparam int PB = 4 * HB;
    localparam logic [PB-1:0] LIM  = {{(PB - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [PB-1:0] LIMN = LIM + PB'(1);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};

    logic [W-1:0]        am;
    logic [W-1:0]        bm;
    logic [DB-1:0]       r_xm;
    logic [DB-1:0]       r_ym;
    logic                r_neg1;
    logic [DB-1:0]       r_p00;
    logic [DB-1:0]       r_p01;
    logic [DB-1:0]       r_p10;
    logic [DB-1:0]       r_p11;
    logic                r_neg2;
    logic [PB-1:0]       r_sum;
    logic                r_neg3;
    logic [PB-1:0]       mag;
    logic signed [W-1:0] n_prod;
    logic                n_ovf;
    logic signed [W-1:0] r_prod;
    logic                r_ovf;

    // Magnitudes of both operands.
    always_comb begin
        am = i_a[W-1] ? W'(-i_a) : W'(i_a);
        bm = i_b[W-1] ? W'(-i_b) : W'(i_b);
    end

    // Stage one holds the magnitudes, stage two the four partial products,
    // stage three their sum.
    always_ff @(posedge i_clk) begin
        r_xm   <= DB'(am);
        r_ym   <= DB'(bm);
        r_neg1 <= i_a[W-1] ^ i_b[W-1];
        r_p00  <= r_xm[HB-1:0] * r_ym[HB-1:0];
        r_p01  <= r_xm[HB-1:0] * r_ym[DB-1:HB];
        r_p10  <= r_xm[DB-1:HB] * r_ym[HB-1:0];
        r_p11  <= r_xm[DB-1:HB] * r_ym[DB-1:HB];
        r_neg2 <= r_neg1;
        r_sum  <= {r_p11, r_p00} + (PB'(r_p01) << HB) + (PB'(r_p10) << HB);
        r_neg3 <= r_neg2;
    end

    // Drop the fraction bits, apply the sign and saturate.
    always_comb begin
        mag    = r_sum >> F;
        n_prod = W'(mag);
        n_ovf  = 1'b0;
        if (r_neg3) begin
            if (mag > LIMN) begin
                n_prod = WMIN;
                n_ovf  = 1'b1;
            end else begin
                n_prod = W'(-mag);
            end
        end else if (mag > LIM) begin
            n_prod = WMAX;
            n_ovf  = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_ovf  <= n_ovf;
    end

    assign o_prod = r_prod;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

// File: hdl/thick_lens_ray_matrix.sv
// Throughput: one request per cycle; busy is never raised.
// Most of the pipeline depth lies in the reciprocal units, which resolve one quotient bit per stage.
// Results cannot be stalled: each is shown for exactly one cycle on o_valid.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
`default_nettype none

module thick_lens_ray_matrix #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [tlrm_pkg::IN_BITS-1:0]   i_radius_front,
    input  wire logic signed [tlrm_pkg::IN_BITS-1:0]   i_radius_back,
    input  wire logic signed [tlrm_pkg::IN_BITS-1:0]   i_thickness,
    input  wire logic        [tlrm_pkg::IDX_BITS-1:0]  i_index,
    output logic                                       o_valid,
    output logic signed [tlrm_pkg::OUT_BITS-1:0]       o_m11,
    output logic signed [tlrm_pkg::OUT_BITS-1:0]       o_m12,
    output logic signed [tlrm_pkg::OUT_BITS-1:0]       o_m21,
    output logic signed [tlrm_pkg::OUT_BITS-1:0]       o_m22,
    output logic                                       o_overflow
);

    import tlrm_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int EW  = (W > IN_BITS ? W : IN_BITS) + 2;
    localparam int RL  = 2 * F + 3;
    localparam int ML  = 4;
    localparam int LAT = 4 + RL + 3 * ML;

    typedef logic signed [EW-1:0] t_ext;

    typedef struct packed {
        logic                ovf;
        logic signed [W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic                       ovf;
        logic signed [OUT_BITS-1:0] val;
    } t_osat;

    // Values carried alongside the reciprocal units.
    typedef struct packed {
        logic                ovf;
        logic                fz;
        logic                bz;
        logic signed [W-1:0] th;
        logic signed [W-1:0] ix;
    } t_dla;

    // Values carried alongside the first row of multipliers.
    typedef struct packed {
        logic                ovf;
        logic signed [W-1:0] nd;
        logic signed [W-1:0] ix;
    } t_dlb;

    // Values carried alongside the second row of multipliers.
    typedef struct packed {
        logic                ovf;
        logic signed [W-1:0] q1;
        logic signed [W-1:0] q2;
        logic signed [W-1:0] q3;
        logic signed [W-1:0] c2;
        logic signed [W-1:0] ix;
    } t_dlc;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = (F < W - 1) ? W'(64'd1 << F) : WMAX;
    localparam t_ext WMAX_E = (t_ext'(1) <<< (W - 1)) - t_ext'(1);
    localparam t_ext WMIN_E = -WMAX_E - t_ext'(1);
    localparam t_ext OMAX_E = (t_ext'(1) <<< (OUT_BITS - 1)) - t_ext'(1);
    localparam t_ext OMIN_E = -OMAX_E - t_ext'(1);

    // Saturate a wide value to the word range.
    function automatic t_sat sat_w(input t_ext v);
        t_sat r;
        r.ovf = 1'b0;
        r.val = W'(v);
        if (v > WMAX_E) begin
            r.ovf = 1'b1;
            r.val = WMAX;
        end else if (v < WMIN_E) begin
            r.ovf = 1'b1;
            r.val = WMIN;
        end
        return r;
    endfunction

    // Saturating add of two words.
    function automatic t_sat s_add(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
        return sat_w(t_ext'(a) + t_ext'(b));
    endfunction

    // Saturating negate: the most negative word becomes the largest word.
    function automatic t_sat s_neg(input logic signed [W-1:0] a);
        t_sat r;
        r.ovf = 1'b0;
        r.val = -a;
        if (a == WMIN) begin
            r.ovf = 1'b1;
            r.val = WMAX;
        end
        return r;
    endfunction

    // Saturate a word to the output range.
    function automatic t_osat sat_o(input logic signed [W-1:0] a);
        t_osat r;
        t_ext  v;
        v     = t_ext'(a);
        r.ovf = 1'b0;
        r.val = OUT_BITS'(v);
        if (v > OMAX_E) begin
            r.ovf = 1'b1;
            r.val = OUT_BITS'(OMAX_E);
        end else if (v < OMIN_E) begin
            r.ovf = 1'b1;
            r.val = OUT_BITS'(OMIN_E);
        end
        return r;
    endfunction

    logic [LAT-1:0] r_vld;

    t_sat                rf_s;
    t_sat                rb_s;
    t_sat                th_s;
    t_sat                ix_s;
    logic signed [W-1:0] r0_rf;
    logic signed [W-1:0] r0_rb;
    logic signed [W-1:0] r0_th;
    logic signed [W-1:0] r0_ix;
    logic                r0_ovf;

    logic signed [W-1:0] rcp_n;
    logic signed [W-1:0] rcp_f;
    logic signed [W-1:0] rcp_b;
    logic                rcp_n_ovf;
    logic                rcp_f_ovf;
    logic                rcp_b_ovf;
    t_dla                r_dla [RL];
    t_dla                dla;

    t_sat                mu_neg;
    t_sat                s1_s;
    t_sat                ix_neg;
    t_sat                s2_s;
    t_sat                nd_s;
    logic                n_p_ovf;
    logic signed [W-1:0] rp_rho1;
    logic signed [W-1:0] rp_rho2;
    logic signed [W-1:0] rp_s1;
    logic signed [W-1:0] rp_s2;
    logic signed [W-1:0] rp_mu1;
    logic signed [W-1:0] rp_nd;
    logic signed [W-1:0] rp_ix;
    logic                rp_ovf;

    logic signed [W-1:0] c1_p;
    logic signed [W-1:0] c2_p;
    logic signed [W-1:0] q1_p;
    logic signed [W-1:0] q2_p;
    logic signed [W-1:0] q3_p;
    logic                c1_o;
    logic                c2_o;
    logic                q1_o;
    logic                q2_o;
    logic                q3_o;
    t_dlb                r_dlb [ML];
    t_dlb                dlb;

    logic signed [W-1:0] e1_p;
    logic signed [W-1:0] e2_p;
    logic                e1_o;
    logic                e2_o;
    t_dlc                r_dlc [ML];
    t_dlc                dlc;

    t_sat                dr00_s;
    logic signed [W-1:0] rq_dr00;
    logic signed [W-1:0] rq_dr01;
    logic signed [W-1:0] rq_dr10;
    logic signed [W-1:0] rq_dr11;
    logic signed [W-1:0] rq_c2;
    logic signed [W-1:0] rq_ix;
    logic                rq_ovf;

    logic signed [W-1:0] f00_p;
    logic signed [W-1:0] f01_p;
    logic signed [W-1:0] g1_p;
    logic signed [W-1:0] g2_p;
    logic signed [W-1:0] g3_p;
    logic signed [W-1:0] g4_p;
    logic                f00_o;
    logic                f01_o;
    logic                g1_o;
    logic                g2_o;
    logic                g3_o;
    logic                g4_o;
    logic                r_dld [ML];

    t_sat                m10_s;
    t_sat                m11_s;
    t_osat               o00_s;
    t_osat               o01_s;
    t_osat               o10_s;
    t_osat               o11_s;
    logic                n_out_ovf;
    logic signed [OUT_BITS-1:0] r_m11;
    logic signed [OUT_BITS-1:0] r_m12;
    logic signed [OUT_BITS-1:0] r_m21;
    logic signed [OUT_BITS-1:0] r_m22;
    logic                r_ovf;

    // The pipeline never stalls, so a request is taken in every cycle.
    assign busy = 1'b0;

    // Valid bits travel with each request through the whole pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // Input stage: fit every field into the word range.
    always_comb begin
        rf_s = sat_w(t_ext'(i_radius_front));
        rb_s = sat_w(t_ext'(i_radius_back));
        th_s = sat_w(t_ext'(i_thickness));
        ix_s = sat_w(t_ext'({1'b0, i_index}));
    end

    always_ff @(posedge i_clk) begin
        r0_rf  <= rf_s.val;
        r0_rb  <= rb_s.val;
        r0_th  <= th_s.val;
        r0_ix  <= ix_s.val;
        r0_ovf <= rf_s.ovf | rb_s.ovf | th_s.ovf | ix_s.ovf;
    end

    // Reciprocals of the index and of both radii.
    tlrm_recip #(.W(W), .F(F)) u_rcp_n (
        .i_clk (i_clk),
        .i_den (r0_ix),
        .o_quo (rcp_n),
        .o_ovf (rcp_n_ovf)
    );

    tlrm_recip #(.W(W), .F(F)) u_rcp_f (
        .i_clk (i_clk),
        .i_den (r0_rf),
        .o_quo (rcp_f),
        .o_ovf (rcp_f_ovf)
    );

    tlrm_recip #(.W(W), .F(F)) u_rcp_b (
        .i_clk (i_clk),
        .i_den (r0_rb),
        .o_quo (rcp_b),
        .o_ovf (rcp_b_ovf)
    );

    // Thickness, index and flags wait for the reciprocals.
    always_ff @(posedge i_clk) begin
        r_dla[0] <= '{ovf: r0_ovf, fz: (r0_rf == '0), bz: (r0_rb == '0),
                      th: r0_th, ix: r0_ix};
        for (int k = 1; k < RL; k++) begin
            r_dla[k] <= r_dla[k-1];
        end
    end

    assign dla = r_dla[RL-1];

    // Curvature terms and the negated thickness. A flat surface has zero curvature
    // and never raises the flag of its reciprocal.
    always_comb begin
        mu_neg  = s_neg(rcp_n);
        s1_s    = s_add(ONE, mu_neg.val);
        ix_neg  = s_neg(dla.ix);
        s2_s    = s_add(ONE, ix_neg.val);
        nd_s    = s_neg(dla.th);
        n_p_ovf = dla.ovf | rcp_n_ovf | (rcp_f_ovf & ~dla.fz) | (rcp_b_ovf & ~dla.bz)
                | mu_neg.ovf | s1_s.ovf | ix_neg.ovf | s2_s.ovf | nd_s.ovf;
    end

    always_ff @(posedge i_clk) begin
        rp_rho1 <= dla.fz ? '0 : rcp_f;
        rp_rho2 <= dla.bz ? '0 : rcp_b;
        rp_s1   <= s1_s.val;
        rp_s2   <= s2_s.val;
        rp_mu1  <= rcp_n;
        rp_nd   <= nd_s.val;
        rp_ix   <= dla.ix;
        rp_ovf  <= n_p_ovf;
    end

    // First row of products: both refraction terms and the parts of D*R1 that need
    // only the front index.
    tlrm_mul #(.W(W), .F(F)) u_m_c1 (
        .i_clk (i_clk), .i_a (rp_rho1), .i_b (rp_s1), .o_prod (c1_p), .o_ovf (c1_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_c2 (
        .i_clk (i_clk), .i_a (rp_rho2), .i_b (rp_s2), .o_prod (c2_p), .o_ovf (c2_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_q1 (
        .i_clk (i_clk), .i_a (rp_nd), .i_b (rp_mu1), .o_prod (q1_p), .o_ovf (q1_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_q2 (
        .i_clk (i_clk), .i_a (ONE), .i_b (rp_mu1), .o_prod (q2_p), .o_ovf (q2_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_q3 (
        .i_clk (i_clk), .i_a (ONE), .i_b (ONE), .o_prod (q3_p), .o_ovf (q3_o)
    );

    always_ff @(posedge i_clk) begin
        r_dlb[0] <= '{ovf: rp_ovf, nd: rp_nd, ix: rp_ix};
        for (int k = 1; k < ML; k++) begin
            r_dlb[k] <= r_dlb[k-1];
        end
    end

    assign dlb = r_dlb[ML-1];

    // Second row of products: the parts of D*R1 that need the front curvature.
    tlrm_mul #(.W(W), .F(F)) u_m_e1 (
        .i_clk (i_clk), .i_a (dlb.nd), .i_b (c1_p), .o_prod (e1_p), .o_ovf (e1_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_e2 (
        .i_clk (i_clk), .i_a (ONE), .i_b (c1_p), .o_prod (e2_p), .o_ovf (e2_o)
    );

    always_ff @(posedge i_clk) begin
        r_dlc[0] <= '{ovf: dlb.ovf | c1_o | c2_o | q1_o | q2_o | q3_o,
                      q1: q1_p, q2: q2_p, q3: q3_p, c2: c2_p, ix: dlb.ix};
        for (int k = 1; k < ML; k++) begin
            r_dlc[k] <= r_dlc[k-1];
        end
    end

    assign dlc = r_dlc[ML-1];

    // Assemble D*R1.
    assign dr00_s = s_add(dlc.q3, e1_p);

    always_ff @(posedge i_clk) begin
        rq_dr00 <= dr00_s.val;
        rq_dr01 <= dlc.q1;
        rq_dr10 <= e2_p;
        rq_dr11 <= dlc.q2;
        rq_c2   <= dlc.c2;
        rq_ix   <= dlc.ix;
        rq_ovf  <= dlc.ovf | e1_o | e2_o | dr00_s.ovf;
    end

    // Third row of products: R2 times D*R1.
    tlrm_mul #(.W(W), .F(F)) u_m_f00 (
        .i_clk (i_clk), .i_a (ONE), .i_b (rq_dr00), .o_prod (f00_p), .o_ovf (f00_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_f01 (
        .i_clk (i_clk), .i_a (ONE), .i_b (rq_dr01), .o_prod (f01_p), .o_ovf (f01_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_g1 (
        .i_clk (i_clk), .i_a (rq_c2), .i_b (rq_dr00), .o_prod (g1_p), .o_ovf (g1_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_g2 (
        .i_clk (i_clk), .i_a (rq_ix), .i_b (rq_dr10), .o_prod (g2_p), .o_ovf (g2_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_g3 (
        .i_clk (i_clk), .i_a (rq_c2), .i_b (rq_dr01), .o_prod (g3_p), .o_ovf (g3_o)
    );

    tlrm_mul #(.W(W), .F(F)) u_m_g4 (
        .i_clk (i_clk), .i_a (rq_ix), .i_b (rq_dr11), .o_prod (g4_p), .o_ovf (g4_o)
    );

    always_ff @(posedge i_clk) begin
        r_dld[0] <= rq_ovf;
        for (int k = 1; k < ML; k++) begin
            r_dld[k] <= r_dld[k-1];
        end
    end

    // Final sums of the bottom row and the fit to the output width.
    always_comb begin
        m10_s     = s_add(g1_p, g2_p);
        m11_s     = s_add(g3_p, g4_p);
        o00_s     = sat_o(f00_p);
        o01_s     = sat_o(f01_p);
        o10_s     = sat_o(m10_s.val);
        o11_s     = sat_o(m11_s.val);
        n_out_ovf = r_dld[ML-1] | f00_o | f01_o | g1_o | g2_o | g3_o | g4_o
                  | m10_s.ovf | m11_s.ovf | o00_s.ovf | o01_s.ovf | o10_s.ovf | o11_s.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_m11 <= o00_s.val;
        r_m12 <= o01_s.val;
        r_m21 <= o10_s.val;
        r_m22 <= o11_s.val;
        r_ovf <= n_out_ovf;
    end

    assign o_valid    = r_vld[LAT-1];
    assign o_m11      = r_m11;
    assign o_m12      = r_m12;
    assign o_m21      = r_m21;
    assign o_m22      = r_m22;
    assign o_overflow = r_ovf;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WMAX = 64'sh7FFF_FFFF;
    localparam longint WMIN = -64'sh8000_0000;
    localparam longint ONE  = 64'sh1_0000;
    localparam int LATENCY = 51;
    localparam int N_RANDOM = 1930;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [tlrm_pkg::IN_BITS-1:0]  r1;
        logic signed [tlrm_pkg::IN_BITS-1:0]  r2;
        logic signed [tlrm_pkg::IN_BITS-1:0]  d;
        logic        [tlrm_pkg::IDX_BITS-1:0] n;
    } lens_t;

    typedef struct {
        logic signed [tlrm_pkg::OUT_BITS-1:0] m11, m12, m21, m22;
        logic ov;
    } matrix_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [tlrm_pkg::IN_BITS-1:0] i_radius_front = '0;
    logic signed [tlrm_pkg::IN_BITS-1:0] i_radius_back = '0;
    logic signed [tlrm_pkg::IN_BITS-1:0] i_thickness = '0;
    logic [tlrm_pkg::IDX_BITS-1:0] i_index = '0;
    logic o_valid;
    logic signed [tlrm_pkg::OUT_BITS-1:0] o_m11, o_m12, o_m21, o_m22;
    logic o_overflow;

    lens_t   pending_lenses[$];
    matrix_t expected_matrices[$];
    int      mismatches = 0;
    int      matrices_seen = 0;
    int      overflow_seen = 0;
    longint  cycle_count = 0;
    bit      stimulus_done = 0;
    bit      calm = 0;

    thick_lens_ray_matrix uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_radius_front(i_radius_front), .i_radius_back(i_radius_back),
        .i_thickness(i_thickness), .i_index(i_index),
        .o_valid(o_valid), .o_m11(o_m11), .o_m12(o_m12), .o_m21(o_m21),
        .o_m22(o_m22), .o_overflow(o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Saturating arithmetic helpers in Q16.16.
    function automatic longint sat_word(longint v, inout bit ov);
        if (v > WMAX) begin ov = 1; return WMAX; end
        if (v < WMIN) begin ov = 1; return WMIN; end
        return v;
    endfunction

    function automatic longint q_mul(longint a, longint b, inout bit ov);
        logic signed [127:0] p;
        logic [127:0] mag;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(a) * 128'(b);
        mag = p[127] ? -p : p;
        mag = mag >> 16;
        if (neg) begin
            if (mag > 128'h8000_0000) begin ov = 1; return WMIN; end
            return -longint'(mag);
        end
        if (mag > 128'h7FFF_FFFF) begin ov = 1; return WMAX; end
        return longint'(mag);
    endfunction

    function automatic longint q_recip(longint den, inout bit ov);
        logic [127:0] mag, q;
        if (den == 0) begin ov = 1; return WMAX; end
        mag = den < 0 ? 128'(-den) : 128'(den);
        q = (128'd1 << 32) / mag;
        if (den < 0) begin
            if (q > 128'h8000_0000) begin ov = 1; return WMIN; end
            return -longint'(q);
        end
        if (q > 128'h7FFF_FFFF) begin ov = 1; return WMAX; end
        return longint'(q);
    endfunction

    function automatic longint q_neg(longint a, inout bit ov);
        if (a == WMIN) begin ov = 1; return WMAX; end
        return -a;
    endfunction

    function automatic longint q_dot(longint a0, longint b0, longint a1, longint b1,
                                     inout bit ov);
        longint p0, p1;
        p0 = q_mul(a0, b0, ov);
        p1 = q_mul(a1, b1, ov);
        return sat_word(p0 + p1, ov);
    endfunction

    // Surface power term: curvature times (1 - mu), flat surfaces give zero.
    function automatic longint surface_power(longint r, longint mu, inout bit ov);
        longint rho, diff;
        rho = (r == 0) ? 0 : q_recip(r, ov);
        diff = sat_word(ONE + q_neg(mu, ov), ov);
        return q_mul(rho, diff, ov);
    endfunction

    // Thick lens matrix M = R2 * D * R1.
    function automatic matrix_t lens_matrix(lens_t l);
        matrix_t m;
        bit ov;
        longint n, mu1, c1, c2, nd, a00, a01, a10, a11;
        ov = 0;
        n = longint'(l.n);
        mu1 = q_recip(n, ov);
        c1 = surface_power(longint'(l.r1), mu1, ov);
        c2 = surface_power(longint'(l.r2), n, ov);
        nd = q_neg(longint'(l.d), ov);
        // D * R1
        a00 = q_dot(ONE, ONE, nd, c1, ov);
        a01 = q_dot(ONE, 0, nd, mu1, ov);
        a10 = q_dot(0, ONE, ONE, c1, ov);
        a11 = q_dot(0, 0, ONE, mu1, ov);
        // R2 * (D * R1)
        m.m11 = 32'(q_dot(ONE, a00, 0, a10, ov));
        m.m12 = 32'(q_dot(ONE, a01, 0, a11, ov));
        m.m21 = 32'(q_dot(c2, a00, n, a10, ov));
        m.m22 = 32'(q_dot(c2, a01, n, a11, ov));
        m.ov = ov;
        return m;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            3: return '0;
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
        endcase
    endfunction

    // Driver: presents the next pending request, idling now and then.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_matrices.push_back(lens_matrix('{i_radius_front, i_radius_back,
                                                          i_thickness, i_index}));
            end
            if ((!start || !busy) && pending_lenses.size() > 0
                && (calm || $urandom_range(0, 99) >= 10)) begin
                lens_t l;
                l = pending_lenses.pop_front();
                start <= 1'b1;
                i_radius_front <= l.r1;
                i_radius_back <= l.r2;
                i_thickness <= l.d;
                i_index <= l.n;
            end else if (!start || !busy) begin
                start <= 1'b0;
                i_radius_front <= $urandom;
                i_index <= 21'($urandom);
                if (pending_lenses.size() == 0) stimulus_done <= 1;
            end
        end
    end

    // Monitor: compares each result strobe with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            matrix_t e;
            if (expected_matrices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
            end else begin
                e = expected_matrices.pop_front();
                matrices_seen++;
                if (o_overflow) overflow_seen++;
                if (o_m11 !== e.m11 || o_m12 !== e.m12 || o_m21 !== e.m21
                    || o_m22 !== e.m22 || o_overflow !== e.ov) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h ov %b, got %h %h %h %h ov %b",
                                 e.m11, e.m12, e.m21, e.m22, e.ov,
                                 o_m11, o_m12, o_m21, o_m22, o_overflow);
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        lens_t l;
        // Directed requests: flat surfaces, extremes, zero and extreme indices.
        pending_lenses.push_back('{0, 0, 0, 21'h10000});
        pending_lenses.push_back('{32'sh0005_0000, -32'sh0005_0000, 32'sh0000_8000, 21'h18000});
        pending_lenses.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 21'h100000});
        pending_lenses.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 21'h1000});
        pending_lenses.push_back('{1, -1, 1, 21'h0});
        pending_lenses.push_back('{-1, 1, -1, 21'h1FFFFF});
        pending_lenses.push_back('{0, 32'sh0010_0000, 32'sh0002_0000, 21'h1});
        pending_lenses.push_back('{32'sh0000_0100, 0, 32'shFFFF_0000, 21'h20000});
        pending_lenses.push_back('{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 21'h1FFFFF});
        pending_lenses.push_back('{32'sh0001_0000, 32'sh0001_0000, 0, 21'h8000});
        repeat (N_RANDOM) begin
            l.r1 = rand_word();
            l.r2 = rand_word();
            l.d = rand_word();
            case ($urandom_range(0, 9))
                0: l.n = 21'($urandom);
                1: l.n = $urandom_range(0, 1) ? 21'h1000 : 21'h100000;
                default: l.n = 21'($urandom_range(21'h1000, 21'h100000));
            endcase
            pending_lenses.push_back(l);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // A stretch without any idling in the middle of the run.
        wait (pending_lenses.size() < 1200);
        calm = 1;
        wait (pending_lenses.size() < 800);
        calm = 0;
        wait (stimulus_done && expected_matrices.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d thick lens matrices, %0d of them with saturation.",
                 matrices_seen, overflow_seen);
        if (mismatches == 0 && expected_matrices.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
